@@ hw/rtl/bsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsf_pkg
// shared types and constants of the border stability filter
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_COUNT_WIDTH = 16;
    localparam int MARGIN_WIDTH    = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE           = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNKNOWN_SWITCH   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BORDER_SWITCH    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_INCONSISTENT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLUR_MARGIN      = 3'd4;

    localparam logic [CFG_COUNT_WIDTH-1:0] RST_UNKNOWN_SWITCH   = 16'd600;
    localparam logic [CFG_COUNT_WIDTH-1:0] RST_BORDER_SWITCH    = 16'd50;
    localparam logic [CFG_COUNT_WIDTH-1:0] RST_MAX_INCONSISTENT = 16'd10;
    localparam logic [MARGIN_WIDTH-1:0]    RST_BLUR_MARGIN      = 8'd1;

    typedef struct packed {
        logic                       enable;
        logic [CFG_COUNT_WIDTH-1:0] unknown_switch;
        logic [CFG_COUNT_WIDTH-1:0] border_switch;
        logic [CFG_COUNT_WIDTH-1:0] max_inconsistent;
        logic [MARGIN_WIDTH-1:0]    blur_margin;
    } t_cfg;

endpackage

@@ hw/rtl/bsf_if.sv @@
// ----------------------------------------------------------------------------
// bsf_if
// channel interfaces: detection input, border result, register writes
// ----------------------------------------------------------------------------
interface bsf_det_if #(
    parameter int BORDER_WIDTH = 12
);
    logic                    valid;
    logic                    ready;
    logic                    det_unknown;
    logic [BORDER_WIDTH-1:0] det_horizontal;
    logic [BORDER_WIDTH-1:0] det_vertical;

    modport source (output valid, output det_unknown, output det_horizontal,
                    output det_vertical, input ready);
    modport sink   (input valid, input det_unknown, input det_horizontal,
                    input det_vertical, output ready);
endinterface

interface bsf_res_if #(
    parameter int BORDER_WIDTH = 12
);
    logic                    valid;
    logic                    ready;
    logic                    changed;
    logic                    out_unknown;
    logic [BORDER_WIDTH-1:0] out_horizontal;
    logic [BORDER_WIDTH-1:0] out_vertical;

    modport source (output valid, output changed, output out_unknown,
                    output out_horizontal, output out_vertical, input ready);
    modport sink   (input valid, input changed, input out_unknown,
                    input out_horizontal, input out_vertical, output ready);
endinterface

interface bsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bsf_blur.sv @@
// ----------------------------------------------------------------------------
// bsf_blur
// adds the blur margin to a nonzero border size, saturating
// ----------------------------------------------------------------------------
module bsf_blur import bsf_pkg::*; #(
    parameter int BORDER_WIDTH = 12
) (
    input  logic [BORDER_WIDTH-1:0] i_size,
    input  logic [MARGIN_WIDTH-1:0] i_margin,
    output logic [BORDER_WIDTH-1:0] o_size
);

    logic [BORDER_WIDTH:0] w_sum;

    assign w_sum = {1'b0, i_size} + (BORDER_WIDTH+1)'(i_margin);

    always_comb begin
        if (i_size == '0) begin
            o_size = '0;
        end else if (w_sum[BORDER_WIDTH]) begin
            o_size = '1;
        end else begin
            o_size = w_sum[BORDER_WIDTH-1:0];
        end
    end

endmodule

@@ hw/rtl/bsf_tracker.sv @@
// ----------------------------------------------------------------------------
// bsf_tracker
// candidate and current border state with consistency counters
// ----------------------------------------------------------------------------
module bsf_tracker import bsf_pkg::*; #(
    parameter int BORDER_WIDTH = 12,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_step,
    input  logic                    i_unknown,
    input  logic [BORDER_WIDTH-1:0] i_horizontal,
    input  logic [BORDER_WIDTH-1:0] i_vertical,
    output logic                    o_changed,
    output logic                    o_unknown,
    output logic [BORDER_WIDTH-1:0] o_horizontal,
    output logic [BORDER_WIDTH-1:0] o_vertical
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_COUNT_WIDTH) ? COUNT_WIDTH : CFG_COUNT_WIDTH;

    logic                    r_cur_unknown,  n_cur_unknown;
    logic [BORDER_WIDTH-1:0] r_cur_h,        n_cur_h;
    logic [BORDER_WIDTH-1:0] r_cur_v,        n_cur_v;
    logic                    r_cand_unknown, n_cand_unknown;
    logic [BORDER_WIDTH-1:0] r_cand_h,       n_cand_h;
    logic [BORDER_WIDTH-1:0] r_cand_v,       n_cand_v;
    logic [COUNT_WIDTH-1:0]  r_cons,         n_cons;
    logic [COUNT_WIDTH-1:0]  r_incons,       n_incons;

    logic                    w_same_cand;
    logic                    w_same_cur;
    logic [COUNT_WIDTH-1:0]  w_cons_inc;
    logic [COUNT_WIDTH-1:0]  w_incons_inc;
    logic                    w_changed;

    assign w_same_cand = i_unknown ? r_cand_unknown
                       : (!r_cand_unknown && i_horizontal == r_cand_h && i_vertical == r_cand_v);
    assign w_same_cur  = r_cur_unknown ? i_unknown
                       : (!i_unknown && i_horizontal == r_cur_h && i_vertical == r_cur_v);
    assign w_cons_inc   = (r_cons == '1) ? r_cons : r_cons + 1'b1;
    assign w_incons_inc = (r_incons == '1) ? r_incons : r_incons + 1'b1;

    always_comb begin
        n_cur_unknown  = r_cur_unknown;
        n_cur_h        = r_cur_h;
        n_cur_v        = r_cur_v;
        n_cand_unknown = r_cand_unknown;
        n_cand_h       = r_cand_h;
        n_cand_v       = r_cand_v;
        n_cons         = r_cons;
        n_incons       = r_incons;
        w_changed      = 1'b0;
        if (!i_cfg.enable) begin
            n_cur_unknown = 1'b1;
            n_cur_h       = '0;
            n_cur_v       = '0;
            w_changed     = 1'b1;
        end else if (w_same_cand ||
                     CMP_WIDTH'(w_incons_inc) > CMP_WIDTH'(i_cfg.max_inconsistent)) begin
            if (w_same_cand) begin
                n_cons   = w_cons_inc;
                n_incons = '0;
            end else begin
                n_incons       = w_incons_inc;
                n_cand_unknown = i_unknown;
                n_cand_h       = i_horizontal;
                n_cand_v       = i_vertical;
                n_cons         = '0;
            end
            if (w_same_cur) begin
                n_incons = '0;
            end else begin
                if (i_unknown) begin
                    w_changed = CMP_WIDTH'(n_cons) == CMP_WIDTH'(i_cfg.unknown_switch);
                end else begin
                    w_changed = r_cur_unknown ||
                                CMP_WIDTH'(n_cons) == CMP_WIDTH'(i_cfg.border_switch);
                end
                if (w_changed) begin
                    n_cur_unknown = i_unknown;
                    n_cur_h       = i_horizontal;
                    n_cur_v       = i_vertical;
                end
            end
        end else begin
            n_incons = w_incons_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_unknown  <= 1'b1;
            r_cur_h        <= '0;
            r_cur_v        <= '0;
            r_cand_unknown <= 1'b1;
            r_cand_h       <= '0;
            r_cand_v       <= '0;
            r_cons         <= '0;
            r_incons       <= COUNT_WIDTH'(RST_MAX_INCONSISTENT);
        end else if (i_step) begin
            r_cur_unknown  <= n_cur_unknown;
            r_cur_h        <= n_cur_h;
            r_cur_v        <= n_cur_v;
            r_cand_unknown <= n_cand_unknown;
            r_cand_h       <= n_cand_h;
            r_cand_v       <= n_cand_v;
            r_cons         <= n_cons;
            r_incons       <= n_incons;
        end
    end

    assign o_changed    = w_changed;
    assign o_unknown    = n_cur_unknown;
    assign o_horizontal = n_cur_h;
    assign o_vertical   = n_cur_v;

endmodule

@@ hw/rtl/border_stability_filter.sv @@
// ----------------------------------------------------------------------------
// border_stability_filter
// steadies per-frame black-border detections into a current border
// ----------------------------------------------------------------------------
// One detection is taken per cycle unless the result side stalls, and one result comes out per detection.
// The result is offered on the result channel after the detection passes
// both registers: the detection is held in an input register, blurred and
// compared against the candidate and current border as it moves on, and
// the outcome is held in a result register until it is taken. Input ready
// drops only while both registers are full and the result side stalls.
// Register writes are taken every cycle; they should be made while no
// detection is in flight. There is no clearing pass after reset.
module border_stability_filter import bsf_pkg::*; #(
    parameter int BORDER_WIDTH = 12,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsf_det_if.sink   i_det,
    bsf_res_if.source o_res,
    bsf_cfg_if.sink   i_cfg
);

    t_cfg                    r_cfg;

    logic                    r_in_valid;
    logic                    r_in_unknown;
    logic [BORDER_WIDTH-1:0] r_in_h;
    logic [BORDER_WIDTH-1:0] r_in_v;

    logic                    r_out_valid;
    logic                    r_out_changed;
    logic                    r_out_unknown;
    logic [BORDER_WIDTH-1:0] r_out_h;
    logic [BORDER_WIDTH-1:0] r_out_v;

    logic                    w_advance;
    logic                    w_in_take;
    logic [BORDER_WIDTH-1:0] w_blur_h;
    logic [BORDER_WIDTH-1:0] w_blur_v;
    logic [BORDER_WIDTH-1:0] w_size_h;
    logic [BORDER_WIDTH-1:0] w_size_v;
    logic                    w_changed;
    logic                    w_unknown;
    logic [BORDER_WIDTH-1:0] w_cur_h;
    logic [BORDER_WIDTH-1:0] w_cur_v;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b1;
            r_cfg.unknown_switch   <= RST_UNKNOWN_SWITCH;
            r_cfg.border_switch    <= RST_BORDER_SWITCH;
            r_cfg.max_inconsistent <= RST_MAX_INCONSISTENT;
            r_cfg.blur_margin      <= RST_BLUR_MARGIN;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENABLE:           r_cfg.enable           <= i_cfg.data[0];
                REG_UNKNOWN_SWITCH:   r_cfg.unknown_switch   <= i_cfg.data;
                REG_BORDER_SWITCH:    r_cfg.border_switch    <= i_cfg.data;
                REG_MAX_INCONSISTENT: r_cfg.max_inconsistent <= i_cfg.data;
                REG_BLUR_MARGIN:      r_cfg.blur_margin      <= i_cfg.data[MARGIN_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake between input register and result register
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_det.ready = !r_in_valid || w_advance;
    assign w_in_take   = i_det.valid && i_det.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_unknown <= i_det.det_unknown;
            r_in_h       <= i_det.det_horizontal;
            r_in_v       <= i_det.det_vertical;
        end
    end

    bsf_blur #(
        .BORDER_WIDTH(BORDER_WIDTH)
    ) u_blur_h (
        .i_size   (r_in_h),
        .i_margin (r_cfg.blur_margin),
        .o_size   (w_blur_h)
    );

    bsf_blur #(
        .BORDER_WIDTH(BORDER_WIDTH)
    ) u_blur_v (
        .i_size   (r_in_v),
        .i_margin (r_cfg.blur_margin),
        .o_size   (w_blur_v)
    );

    // sizes of an unknown detection are dropped
    assign w_size_h = r_in_unknown ? '0 : w_blur_h;
    assign w_size_v = r_in_unknown ? '0 : w_blur_v;

    bsf_tracker #(
        .BORDER_WIDTH(BORDER_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_step       (w_advance),
        .i_unknown    (r_in_unknown),
        .i_horizontal (w_size_h),
        .i_vertical   (w_size_v),
        .o_changed    (w_changed),
        .o_unknown    (w_unknown),
        .o_horizontal (w_cur_h),
        .o_vertical   (w_cur_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_changed <= w_changed;
            r_out_unknown <= w_unknown;
            r_out_h       <= w_cur_h;
            r_out_v       <= w_cur_v;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.changed        = r_out_changed;
    assign o_res.out_unknown    = r_out_unknown;
    assign o_res.out_horizontal = r_out_h;
    assign o_res.out_vertical   = r_out_v;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !w_advance)
        else $error("result register overwritten while stalled");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item did not reach result register");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |-> !i_det.ready)
        else $error("input accepted while input register held");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_unknown |-> r_out_h == '0 && r_out_v == '0)
        else $error("unknown border with nonzero sizes");
`endif

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the border stability filter
// ----------------------------------------------------------------------------
// Sends detections over the valid/ready channel with random gaps on both
// sides, keeps its own copy of the filter state and register settings, and
// checks every returned border field by field against the predicted one.
// Directed frames cover the reset settings, margin saturation and the
// disabled mode. Random phases each change the settings before sending
// bursts of repeated borders. A long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_top import bsf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW           = 12;
    localparam int CW           = 16;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_TICKS = 4;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic          unk;
        logic [BW-1:0] h;
        logic [BW-1:0] v;
    } border_t;

    typedef struct packed {
        logic    changed;
        border_t border;
    } border_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsf_det_if #(.BORDER_WIDTH(BW)) det_bus ();
    bsf_res_if #(.BORDER_WIDTH(BW)) res_bus ();
    bsf_cfg_if                      cfg_bus ();

    border_stability_filter #(
        .BORDER_WIDTH(BW),
        .COUNT_WIDTH (CW)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_det  (det_bus),
        .o_res  (res_bus),
        .i_cfg  (cfg_bus)
    );

    // shadow of the filter
    t_cfg          reg_shadow;
    border_t       cur_border;
    border_t       cand_border;
    logic [CW-1:0] consistent_cnt;
    logic [CW-1:0] inconsistent_cnt;

    border_result_t pending_borders [$];
    border_result_t want;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles = 0;
    int mismatch_cnt   = 0;
    int result_cnt     = 0;
    int stall_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic same_border(border_t a, border_t b);
        return a.unk ? b.unk : (!b.unk && a.h == b.h && a.v == b.v);
    endfunction

    function automatic logic [BW-1:0] add_margin(logic [BW-1:0] size);
        logic [BW:0] sum;
        sum = {1'b0, size} + {{(BW + 1 - MARGIN_WIDTH){1'b0}}, reg_shadow.blur_margin};
        if (size == '0) return '0;
        return sum[BW] ? '1 : sum[BW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] c);
        return (c == '1) ? c : c + CW'(1);
    endfunction

    function automatic border_result_t predict_border(border_t det);
        border_t nb;
        logic    chg;
        logic    evaluate;
        chg      = 1'b0;
        evaluate = 1'b1;
        if (!reg_shadow.enable) begin
            cur_border = '{unk: 1'b1, h: '0, v: '0};
            chg        = 1'b1;
        end else begin
            nb.unk = det.unk;
            nb.h   = det.unk ? '0 : add_margin(det.h);
            nb.v   = det.unk ? '0 : add_margin(det.v);
            if (same_border(nb, cand_border)) begin
                consistent_cnt   = sat_inc(consistent_cnt);
                inconsistent_cnt = '0;
            end else begin
                inconsistent_cnt = sat_inc(inconsistent_cnt);
                if (inconsistent_cnt > reg_shadow.max_inconsistent) begin
                    cand_border    = nb;
                    consistent_cnt = '0;
                end else begin
                    evaluate = 1'b0;
                end
            end
            if (evaluate && same_border(cur_border, nb)) begin
                inconsistent_cnt = '0;
            end else if (evaluate) begin
                chg = nb.unk ? (consistent_cnt == reg_shadow.unknown_switch)
                             : (cur_border.unk || consistent_cnt == reg_shadow.border_switch);
                if (chg) cur_border = nb;
            end
        end
        return '{changed: chg, border: cur_border};
    endfunction

    function automatic border_t det_item(logic unk, int unsigned h, int unsigned v);
        return '{unk: unk, h: BW'(h), v: BW'(v)};
    endfunction

    function automatic border_t random_det();
        return '{unk: 1'($urandom_range(1)), h: BW'($urandom), v: BW'($urandom)};
    endfunction

    function automatic logic [BW-1:0] pick_size();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return BW'($urandom_range(8));
            default: return BW'($urandom);
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return CW'($urandom);
            default: return CW'($urandom_range(6));
        endcase
    endfunction

    function automatic logic [MARGIN_WIDTH-1:0] pick_margin();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return MARGIN_WIDTH'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < MAX_REPORTS) $display("result %0d: %s", result_cnt, msg);
        mismatch_cnt++;
    endtask

    // entered and left on a falling edge
    task automatic send_det(border_t d);
        while ($urandom_range(99) < tx_idle_pct) begin
            det_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        det_bus.valid          <= 1'b1;
        det_bus.det_unknown    <= d.unk;
        det_bus.det_horizontal <= d.h;
        det_bus.det_vertical   <= d.v;
        do @(posedge i_clk); while (!det_bus.ready);
        pending_borders.push_back(predict_border(d));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_ENABLE:           reg_shadow.enable           = val[0];
            REG_UNKNOWN_SWITCH:   reg_shadow.unknown_switch   = val;
            REG_BORDER_SWITCH:    reg_shadow.border_switch    = val;
            REG_MAX_INCONSISTENT: reg_shadow.max_inconsistent = val;
            REG_BLUR_MARGIN:      reg_shadow.blur_margin      = val[MARGIN_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        det_bus.valid <= 1'b0;
        while (pending_borders.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic test_reset_settings();
        send_det(det_item(1'b0, 0, 0));
        send_det(det_item(1'b1, 4095, 4095));
        send_det(det_item(1'b0, 4095, 4094));
        send_det(det_item(1'b0, 4094, 4095));
        send_det(det_item(1'b1, 0, 0));
        send_det(det_item(1'b0, 1, 2048));
    endtask

    task automatic test_blur_margin();
        drain();
        write_reg(REG_BLUR_MARGIN, 16'hFFFF);
        write_reg(REG_MAX_INCONSISTENT, 16'd0);
        write_reg(REG_BORDER_SWITCH, 16'd0);
        write_reg(REG_UNKNOWN_SWITCH, 16'd0);
        send_det(det_item(1'b0, 4095, 1));
        send_det(det_item(1'b0, 3840, 0));
        send_det(det_item(1'b0, 3841, 4095));
        send_det(det_item(1'b1, 5, 5));
        drain();
        write_reg(REG_BLUR_MARGIN, 16'hFF00);
        send_det(det_item(1'b0, 4095, 4095));
        send_det(det_item(1'b0, 1, 1));
    endtask

    task automatic test_disable();
        drain();
        write_reg(REG_ENABLE, 16'hFFFE);
        send_det(det_item(1'b0, 100, 200));
        send_det(det_item(1'b1, 0, 0));
        send_det(det_item(1'b0, 4095, 4095));
        drain();
        write_reg(REG_ENABLE, 16'hFFFF);
        send_det(det_item(1'b0, 100, 200));
        send_det(det_item(1'b0, 100, 200));
        send_det(det_item(1'b1, 7, 9));
    endtask

    task automatic randomize_registers();
        logic [CFG_DATA_WIDTH-1:0]  data;
        logic [CFG_INDEX_WIDTH-1:0] spare_idx;
        data    = CFG_DATA_WIDTH'($urandom);
        data[0] = ($urandom_range(9) != 0);
        write_reg(REG_ENABLE, data);
        write_reg(REG_UNKNOWN_SWITCH, pick_count());
        write_reg(REG_BORDER_SWITCH, pick_count());
        write_reg(REG_MAX_INCONSISTENT, pick_count());
        data                    = CFG_DATA_WIDTH'($urandom);
        data[MARGIN_WIDTH-1:0]  = pick_margin();
        write_reg(REG_BLUR_MARGIN, data);
        if ($urandom_range(3) == 0) begin
            spare_idx = CFG_INDEX_WIDTH'($urandom_range((1 << CFG_INDEX_WIDTH) - 1,
                                                        REG_BLUR_MARGIN + 1));
            write_reg(spare_idx, CFG_DATA_WIDTH'($urandom));
        end
    endtask

    // bursts of repeated borders from a small pool, with some noise frames
    task automatic test_random_traffic(int n_items);
        border_t pool [4];
        border_t d;
        int      sent;
        int      phase_end;
        sent = 0;
        while (sent < n_items) begin
            drain();
            randomize_registers();
            foreach (pool[i]) pool[i] = '{unk: ($urandom_range(3) == 0),
                                          h: pick_size(), v: pick_size()};
            phase_end = sent + $urandom_range(20, 40);
            while (sent < phase_end && sent < n_items) begin
                if ($urandom_range(99) < 15) begin
                    send_det(random_det());
                    sent++;
                end else begin
                    d = pool[$urandom_range(3)];
                    repeat ($urandom_range(1, 8)) begin
                        if (d.unk) begin
                            d.h = BW'($urandom);
                            d.v = BW'($urandom);
                        end
                        send_det(d);
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic test_backpressure();
        drain();
        rx_hold_cycles = 60;
        repeat (16) send_det(random_det());
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            res_bus.ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_borders.size() == 0) begin
                report_mismatch("transfer with no border pending");
            end else begin
                want = pending_borders.pop_front();
                if (res_bus.changed !== want.changed)
                    report_mismatch($sformatf("changed %0h, expected %0h",
                                              res_bus.changed, want.changed));
                if (res_bus.out_unknown !== want.border.unk)
                    report_mismatch($sformatf("out_unknown %0h, expected %0h",
                                              res_bus.out_unknown, want.border.unk));
                if (res_bus.out_horizontal !== want.border.h)
                    report_mismatch($sformatf("out_horizontal %0h, expected %0h",
                                              res_bus.out_horizontal, want.border.h));
                if (res_bus.out_vertical !== want.border.v)
                    report_mismatch($sformatf("out_vertical %0h, expected %0h",
                                              res_bus.out_vertical, want.border.v));
            end
            result_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if ((det_bus.valid && det_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        det_bus.valid          = 1'b0;
        det_bus.det_unknown    = 1'b0;
        det_bus.det_horizontal = '0;
        det_bus.det_vertical   = '0;
        res_bus.ready          = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        i_rst_n                = 1'b0;
        reg_shadow = '{enable: 1'b1, unknown_switch: RST_UNKNOWN_SWITCH,
                       border_switch: RST_BORDER_SWITCH,
                       max_inconsistent: RST_MAX_INCONSISTENT,
                       blur_margin: RST_BLUR_MARGIN};
        cur_border       = '{unk: 1'b1, h: '0, v: '0};
        cand_border      = '{unk: 1'b1, h: '0, v: '0};
        consistent_cnt   = '0;
        inconsistent_cnt = RST_MAX_INCONSISTENT;
        tx_idle_pct      = 12;
        rx_idle_pct      = 57;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_blur_margin();
        test_disable();
        test_random_traffic(175);
        tx_idle_pct = 57;
        rx_idle_pct = 12;
        test_random_traffic(175);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(170);
        test_backpressure();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
